### src/capdu_pkg.sv
package capdu_pkg;

   localparam int unsigned APDU_CAPACITY_DEFAULT = 1024;
   localparam int unsigned HEADER_MIN_LEN = 23;
   localparam int unsigned TITLE_MAX = 8;

   localparam logic [7:0] LEN_SHORT_MAX = 8'h80;
   localparam logic [7:0] LEN_LONG_1 = 8'h81;
   localparam logic [7:0] LEN_LONG_2 = 8'h82;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_BATCH_END = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_start;
      logic       header_packet;
      logic [7:0] packet_length;
      logic       batch_start;
      logic       batch_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  payload_byte;
      logic [9:0]  payload_index;
      logic [7:0]  cipher_tag;
      logic [3:0]  title_length;
      logic [63:0] title_bytes;
      logic [15:0] announced_length;
      logic [7:0]  security_control;
      logic [31:0] invocation_count;
      logic [10:0] final_length;
      logic        last_result;
   } rsp_type;

endpackage

### src/ciphered_apdu_header_parser_unit.sv
// Ciphered APDU header parser.
// Request channel (req_valid / req_stall / req_data) carries one bus packet byte per
// transaction, with packet and batch framing flags. A header packet longer than 23 bytes
// yields one header transaction (cipher service, system title, announced length,
// security byte, frame counter); the body bytes that follow, and those of continuation
// packets that fit, come out as payload transactions with their buffer index. The last
// byte of a batch adds a batch-end transaction with the collected length.
// Each request causes zero, one or two response transactions; last_result marks the
// last one of a request.
// The responses of a request are written into the output buffer when it is accepted and
// appear on rsp_data from its head; a second one follows once the first is taken.
// Throughput: one request per cycle while req_stall is low. Results queue in a four-entry
// output buffer, and req_stall rises while fewer than two entries are free, so a run of
// requests that each cause two results drains at one result per cycle while rsp_stall is
// low. When the receiver holds rsp_stall the buffer fills and backpressure reaches the
// request side after at most three more requests that each cause a result.
// Reset (synchronous, active high) empties the buffer and returns the parser to idle
// with all header fields and the running length cleared.
module ciphered_apdu_header_parser_unit #(
   parameter int unsigned APDU_CAPACITY = capdu_pkg::APDU_CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  capdu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output capdu_pkg::rsp_type rsp_data
);
   import capdu_pkg::*;

   localparam int unsigned RUN_W = $clog2(APDU_CAPACITY + 1);
   localparam int unsigned CMP_W = 17;
   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_CIPHER,
      PH_TLEN,
      PH_TITLE,
      PH_LEN,
      PH_L82HI,
      PH_L82LO,
      PH_L81,
      PH_SEC,
      PH_FC,
      PH_BODY
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [3:0]       field_count_ff, field_count_in;
   logic [7:0]       remaining_ff, remaining_in;
   logic             copy_ff, copy_in;
   logic [7:0]       cipher_ff, cipher_in;
   logic [3:0]       title_len_ff, title_len_in;
   logic [63:0]      title_ff, title_in;
   logic [15:0]      announced_ff, announced_in;
   logic [7:0]       security_ff, security_in;
   logic [31:0]      counter_ff, counter_in;
   logic [RUN_W-1:0] running_ff, running_in;

   rsp_type          fifo_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             req_accept;
   logic             rsp_accept;
   logic             byte_res_valid;
   rsp_type          byte_res;
   rsp_type          end_res;
   logic [CMP_W-1:0] run_ext;
   logic [CMP_W-1:0] cap_ext;
   logic [7:0]       b;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = count_ff > CNT_W'(DEPTH - 2);
   assign rsp_valid  = count_ff != '0;
   assign rsp_data   = fifo_ff[head_ff];
   assign cap_ext    = CMP_W'(APDU_CAPACITY);
   assign b          = req_data.data_byte;

   always_comb begin
      phase_in       = phase_ff;
      field_count_in = field_count_ff;
      remaining_in   = remaining_ff;
      copy_in        = copy_ff;
      cipher_in      = cipher_ff;
      title_len_in   = title_len_ff;
      title_in       = title_ff;
      announced_in   = announced_ff;
      security_in    = security_ff;
      counter_in     = counter_ff;
      running_in     = running_ff;
      byte_res_valid = 1'b0;
      byte_res       = '0;
      end_res        = '0;
      run_ext        = '0;

      if (req_accept) begin
         if (req_data.batch_start) begin
            running_in = '0;
         end

         if (req_data.packet_start) begin
            remaining_in   = req_data.packet_length;
            field_count_in = '0;
            if (req_data.header_packet) begin
               if (req_data.packet_length > 8'(HEADER_MIN_LEN)) begin
                  phase_in = PH_CIPHER;
                  copy_in  = CMP_W'(req_data.packet_length) <= cap_ext;
               end else begin
                  phase_in = PH_IDLE;
                  copy_in  = 1'b0;
               end
            end else begin
               copy_in  = (CMP_W'(running_in) + CMP_W'(req_data.packet_length) <= cap_ext)
                          && (CMP_W'(running_in) < CMP_W'(announced_ff));
               phase_in = PH_BODY;
            end
         end

         if (remaining_in != '0) begin
            remaining_in = remaining_in - 8'd1;
            unique case (phase_in)
               PH_CIPHER: begin
                  cipher_in = b;
                  phase_in  = PH_TLEN;
               end
               PH_TLEN: begin
                  title_len_in   = (b > 8'(TITLE_MAX)) ? 4'(TITLE_MAX) : b[3:0];
                  title_in       = '0;
                  field_count_in = '0;
                  phase_in       = (title_len_in != '0) ? PH_TITLE : PH_LEN;
               end
               PH_TITLE: begin
                  // first title byte lands in the top byte
                  title_in[{~field_count_in[2:0], 3'b000} +: 8] =
                     title_in[{~field_count_in[2:0], 3'b000} +: 8] | b;
                  field_count_in = field_count_in + 4'd1;
                  if (field_count_in >= title_len_in) begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if (b <= LEN_SHORT_MAX) begin
                     announced_in = 16'(b);
                     phase_in     = PH_SEC;
                  end else if (b == LEN_LONG_2) begin
                     phase_in = PH_L82HI;
                  end else if (b == LEN_LONG_1) begin
                     phase_in = PH_L81;
                  end else begin
                     // unknown length form: take the byte as security control
                     security_in    = b;
                     field_count_in = '0;
                     counter_in     = '0;
                     phase_in       = PH_FC;
                  end
               end
               PH_L82HI: begin
                  announced_in = {b, 8'h00};
                  phase_in     = PH_L82LO;
               end
               PH_L82LO: begin
                  announced_in = announced_in | 16'(b);
                  phase_in     = PH_SEC;
               end
               PH_L81: begin
                  announced_in = 16'(b);
                  phase_in     = PH_SEC;
               end
               PH_SEC: begin
                  security_in    = b;
                  field_count_in = '0;
                  counter_in     = '0;
                  phase_in       = PH_FC;
               end
               PH_FC: begin
                  counter_in     = {counter_in[23:0], b};
                  field_count_in = field_count_in + 4'd1;
                  if (field_count_in >= 4'd4) begin
                     if (copy_in) begin
                        running_in = '0;
                     end
                     phase_in                  = PH_BODY;
                     byte_res_valid            = 1'b1;
                     byte_res.result_kind      = KIND_HEADER;
                     byte_res.cipher_tag       = cipher_in;
                     byte_res.title_length     = title_len_in;
                     byte_res.title_bytes      = title_in;
                     byte_res.announced_length = announced_in;
                     byte_res.security_control = security_in;
                     byte_res.invocation_count = counter_in;
                  end
               end
               PH_BODY: begin
                  if (copy_in && (CMP_W'(running_in) < cap_ext)) begin
                     run_ext                = CMP_W'(running_in);
                     byte_res_valid         = 1'b1;
                     byte_res.result_kind   = KIND_PAYLOAD;
                     byte_res.payload_byte  = b;
                     byte_res.payload_index = run_ext[9:0];
                     running_in             = running_in + RUN_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end

         byte_res.last_result = !req_data.batch_end;

         if (req_data.batch_end) begin
            run_ext              = CMP_W'(running_in);
            end_res.result_kind  = KIND_BATCH_END;
            end_res.final_length = run_ext[10:0];
            end_res.last_result  = 1'b1;
            announced_in         = run_ext[15:0];
            phase_in             = PH_IDLE;
            remaining_in         = '0;
            copy_in              = 1'b0;
         end
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (rsp_accept) begin
         head_in  = head_ff + PTR_W'(1);
         count_in = count_in - CNT_W'(1);
      end
      if (req_accept) begin
         tail_in  = tail_ff + PTR_W'(byte_res_valid) + PTR_W'(req_data.batch_end);
         count_in = count_in + CNT_W'(byte_res_valid) + CNT_W'(req_data.batch_end);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         field_count_ff <= '0;
         remaining_ff   <= '0;
         copy_ff        <= 1'b0;
         cipher_ff      <= '0;
         title_len_ff   <= '0;
         title_ff       <= '0;
         announced_ff   <= '0;
         security_ff    <= '0;
         counter_ff     <= '0;
         running_ff     <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         field_count_ff <= field_count_in;
         remaining_ff   <= remaining_in;
         copy_ff        <= copy_in;
         cipher_ff      <= cipher_in;
         title_len_ff   <= title_len_in;
         title_ff       <= title_in;
         announced_ff   <= announced_in;
         security_ff    <= security_in;
         counter_ff     <= counter_in;
         running_ff     <= running_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
      end
   end

   // buffer entries carry no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (byte_res_valid) begin
            fifo_ff[tail_ff] <= byte_res;
         end
         if (req_data.batch_end) begin
            fifo_ff[tail_ff + PTR_W'(byte_res_valid)] <= end_res;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("output buffer count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty buffer with misaligned pointers");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_BATCH_END) |-> rsp_data.last_result)
      else $error("batch end result not marked last");

   assert property (@(posedge clock) disable iff (reset)
      (title_len_ff <= 4'(TITLE_MAX)) && (field_count_ff <= 4'(TITLE_MAX)))
      else $error("title length or field count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (running_ff <= RUN_W'(APDU_CAPACITY)))
      else $error("running length beyond capacity");

endmodule
